FILE: rtl/asm_pkg.sv
// Shared types and constants for the adaptive stroke smoother.
// Used by the front end, the job queue, the back end and the top level.
package asm_pkg;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam int SF_W = 17;
  localparam int TIME_W = 32;
  localparam int PRES_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_FACTOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 1'b1;

  localparam logic [SF_W-1:0] SF_ONE = 17'd65536;
  localparam logic [SF_W-1:0] SF_RESET = 17'd32768;
  localparam logic [CFG_DATA_W-1:0] SPEED_RESET = 32'd65536;

  // Reciprocal of ten in 19 fractional bits; exact for the slow weight range.
  localparam logic [15:0] RECIP_TEN = 16'd52429;
  localparam int RECIP_SHIFT = 19;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    JOB_SINGLE = 2'd0,
    JOB_PASS   = 2'd1,
    JOB_SMOOTH = 2'd2
  } job_kind_t;

  typedef struct packed {
    logic [SF_W-1:0]       smooth_factor;
    logic [CFG_DATA_W-1:0] speed_limit;
  } cfg_t;

endpackage

FILE: rtl/asm_queue.sv
// Short job queue between the front end and the back end.
// Depends on asm_pkg for the queue depth.
module asm_queue import asm_pkg::*; #(
  parameter int DATA_W = 275
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output logic [DATA_W-1:0] pop_data
);

  logic [DATA_W-1:0] mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop = pop && pop_valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      count_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/asm_front.sv
// Front end: accepts pen points, keeps the point window and issues jobs.
// Depends on asm_pkg for the job kinds and field widths.
module asm_front import asm_pkg::*; #(
  parameter int CW = 24,
  localparam int JobW = 6 * CW + 131
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [CW-1:0]     in_x,
  input  logic signed [CW-1:0]     in_y,
  input  logic [PRES_W-1:0]        in_pressure,
  input  logic [TIME_W-1:0]        in_time,
  input  logic                     in_stroke_end,
  output logic                     job_push,
  output logic [JobW-1:0]          job_data,
  input  logic                     job_full
);

  typedef struct packed {
    job_kind_t          kind;
    logic               stroke_end;
    logic signed [CW-1:0] prev_x;
    logic signed [CW-1:0] prev_y;
    logic [TIME_W-1:0]  prev_t;
    logic signed [CW-1:0] held_x;
    logic signed [CW-1:0] held_y;
    logic [PRES_W-1:0]  held_p;
    logic [TIME_W-1:0]  held_t;
    logic signed [CW-1:0] new_x;
    logic signed [CW-1:0] new_y;
    logic [PRES_W-1:0]  new_p;
    logic [TIME_W-1:0]  new_t;
  } job_t;

  logic signed [CW-1:0] prev_x_r, prev_y_r, held_x_r, held_y_r;
  logic [TIME_W-1:0]    prev_t_r, held_t_r;
  logic [PRES_W-1:0]    held_p_r;
  logic [1:0]           seen_r, seen_nxt;
  logic                 accept, shift;
  job_t                 job;

  assign in_stall = job_full;
  assign accept = in_valid && !job_full;

  always_comb begin
    job.kind = JOB_SMOOTH;
    job.stroke_end = in_stroke_end;
    job.prev_x = prev_x_r;
    job.prev_y = prev_y_r;
    job.prev_t = prev_t_r;
    job.held_x = held_x_r;
    job.held_y = held_y_r;
    job.held_p = held_p_r;
    job.held_t = held_t_r;
    job.new_x = in_x;
    job.new_y = in_y;
    job.new_p = in_pressure;
    job.new_t = in_time;
    job_push = 1'b0;
    shift = 1'b0;
    seen_nxt = seen_r;
    if (accept) begin
      case (seen_r)
        2'd0: begin
          job.kind = JOB_SINGLE;
          job_push = in_stroke_end;
          shift = !in_stroke_end;
          seen_nxt = in_stroke_end ? 2'd0 : 2'd1;
        end
        2'd1: begin
          job.kind = JOB_PASS;
          job_push = 1'b1;
          shift = 1'b1;
          seen_nxt = in_stroke_end ? 2'd0 : 2'd2;
        end
        default: begin
          job.kind = JOB_SMOOTH;
          job_push = 1'b1;
          shift = 1'b1;
          seen_nxt = in_stroke_end ? 2'd0 : 2'd2;
        end
      endcase
    end
  end

  assign job_data = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 2'd0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      prev_x_r <= held_x_r;
      prev_y_r <= held_y_r;
      prev_t_r <= held_t_r;
      held_x_r <= in_x;
      held_y_r <= in_y;
      held_p_r <= in_pressure;
      held_t_r <= in_time;
    end
  end

endmodule

FILE: rtl/asm_back.sv
// Back end: speed test and weighted move for smoothing jobs; drives the
// output register. Depends on asm_pkg for job kinds and configuration.
module asm_back import asm_pkg::*; #(
  parameter int CW = 24,
  localparam int JobW = 6 * CW + 131
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic                 job_valid,
  input  logic [JobW-1:0]      job_data,
  output logic                 job_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [CW-1:0] out_x,
  output logic signed [CW-1:0] out_y,
  output logic [PRES_W-1:0]    out_pressure,
  output logic [TIME_W-1:0]    out_time,
  output logic                 out_last
);

  typedef struct packed {
    job_kind_t          kind;
    logic               stroke_end;
    logic signed [CW-1:0] prev_x;
    logic signed [CW-1:0] prev_y;
    logic [TIME_W-1:0]  prev_t;
    logic signed [CW-1:0] held_x;
    logic signed [CW-1:0] held_y;
    logic [PRES_W-1:0]  held_p;
    logic [TIME_W-1:0]  held_t;
    logic signed [CW-1:0] new_x;
    logic signed [CW-1:0] new_y;
    logic [PRES_W-1:0]  new_p;
    logic [TIME_W-1:0]  new_t;
  } job_t;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_MUL1  = 9'b000000010,
    ST_MUL2  = 9'b000000100,
    ST_SUM   = 9'b000001000,
    ST_CMP   = 9'b000010000,
    ST_MOV   = 9'b000100000,
    ST_RND   = 9'b001000000,
    ST_EMIT1 = 9'b010000000,
    ST_EMIT2 = 9'b100000000
  } state_t;

  localparam int DW = CW + 1;
  localparam int SQ_W = 2 * DW;
  localparam int SUM_W = SQ_W + 1;
  localparam int D2_W = CW + 2;
  localparam int MV_W = D2_W + SF_W + 2;

  state_t state_r, state_nxt;
  job_t   job_r;

  logic [SQ_W-1:0]         dx2_r, dy2_r;
  logic [63:0]             p_r;
  logic                    dt_nz_r;
  logic [SF_W-1:0]         w_slow_r, w_r;
  logic [63:0]             pll_r, plh_r, phh_r;
  logic [SUM_W-1:0]        sq_sum_r;
  logic [127:0]            rr_r, lhs_r;
  logic signed [D2_W-1:0]  d2x_r, d2y_r;
  logic signed [MV_W-1:0]  mvx_r, mvy_r;
  logic signed [CW-1:0]    res_x_r, res_y_r;

  logic signed [DW-1:0]    dx, dy;
  logic [DW-1:0]           mag_x, mag_y;
  logic [TIME_W-1:0]       dt;
  logic [17:0]             sf3;
  logic [33:0]             wprod;
  logic signed [SF_W:0]    w_sig;
  logic signed [MV_W-1:0]  rx, ry;
  logic signed [MV_W-1:0]  sat_hi, sat_lo;
  logic                    out_free, out_load;

  assign out_free = !out_valid || !out_stall;
  assign job_pop = (state_r == ST_IDLE) && job_valid;

  assign sat_hi = $signed({{(MV_W - CW + 1){1'b0}}, {(CW - 1){1'b1}}});
  assign sat_lo = $signed({{(MV_W - CW + 1){1'b1}}, {(CW - 1){1'b0}}});

  always_comb begin
    dx = $signed({job_r.held_x[CW-1], job_r.held_x}) -
         $signed({job_r.prev_x[CW-1], job_r.prev_x});
    dy = $signed({job_r.held_y[CW-1], job_r.held_y}) -
         $signed({job_r.prev_y[CW-1], job_r.prev_y});
    mag_x = dx[DW-1] ? DW'(-dx) : DW'(dx);
    mag_y = dy[DW-1] ? DW'(-dy) : DW'(dy);
    dt = (job_r.held_t >= job_r.prev_t) ? job_r.held_t - job_r.prev_t
                                        : job_r.prev_t - job_r.held_t;
    sf3 = 18'({1'b0, cfg.smooth_factor} * 18'd3) + 18'd5;
    wprod = 34'(sf3) * 34'(RECIP_TEN);
    w_sig = $signed({1'b0, w_r});
    rx = $signed({{(MV_W - CW){job_r.held_x[CW-1]}}, job_r.held_x}) + (mvx_r >>> 17);
    ry = $signed({{(MV_W - CW){job_r.held_y[CW-1]}}, job_r.held_y}) + (mvy_r >>> 17);
  end

  always_comb begin
    state_nxt = state_r;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          state_nxt = (job_kind_t'(job_data[JobW-1 -: 2]) == JOB_SMOOTH) ? ST_MUL1
                                                                        : ST_EMIT1;
        end
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_MOV;
      ST_MOV:  state_nxt = ST_RND;
      ST_RND:  state_nxt = ST_EMIT1;
      ST_EMIT1: begin
        if (out_free) begin
          out_load = 1'b1;
          state_nxt = (job_r.kind != JOB_SINGLE && job_r.stroke_end) ? ST_EMIT2 : ST_IDLE;
        end
      end
      ST_EMIT2: begin
        if (out_free) begin
          out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r <= job_t'(job_data);
    end
    if (state_r == ST_MUL1) begin
      dx2_r <= SQ_W'(mag_x) * SQ_W'(mag_x);
      dy2_r <= SQ_W'(mag_y) * SQ_W'(mag_y);
      p_r <= 64'(cfg.speed_limit) * 64'(dt);
      dt_nz_r <= (dt != '0);
      w_slow_r <= SF_W'(wprod >> RECIP_SHIFT);
    end
    if (state_r == ST_MUL2) begin
      pll_r <= 64'(p_r[31:0]) * 64'(p_r[31:0]);
      plh_r <= 64'(p_r[31:0]) * 64'(p_r[63:32]);
      phh_r <= 64'(p_r[63:32]) * 64'(p_r[63:32]);
      sq_sum_r <= SUM_W'(dx2_r) + SUM_W'(dy2_r);
    end
    if (state_r == ST_SUM) begin
      rr_r <= {phh_r, 64'd0} + (128'(plh_r) << 33) + 128'(pll_r);
      lhs_r <= 128'(sq_sum_r) << 16;
    end
    if (state_r == ST_CMP) begin
      w_r <= (dt_nz_r && (lhs_r > rr_r)) ? cfg.smooth_factor : w_slow_r;
      d2x_r <= $signed({{2{job_r.prev_x[CW-1]}}, job_r.prev_x}) +
               $signed({{2{job_r.new_x[CW-1]}}, job_r.new_x}) -
               $signed({job_r.held_x[CW-1], job_r.held_x, 1'b0});
      d2y_r <= $signed({{2{job_r.prev_y[CW-1]}}, job_r.prev_y}) +
               $signed({{2{job_r.new_y[CW-1]}}, job_r.new_y}) -
               $signed({job_r.held_y[CW-1], job_r.held_y, 1'b0});
    end
    if (state_r == ST_MOV) begin
      mvx_r <= w_sig * d2x_r + $signed(MV_W'(65536));
      mvy_r <= w_sig * d2y_r + $signed(MV_W'(65536));
    end
    if (state_r == ST_RND) begin
      res_x_r <= (rx > sat_hi) ? sat_hi[CW-1:0] : (rx < sat_lo) ? sat_lo[CW-1:0]
                                                                : rx[CW-1:0];
      res_y_r <= (ry > sat_hi) ? sat_hi[CW-1:0] : (ry < sat_lo) ? sat_lo[CW-1:0]
                                                                : ry[CW-1:0];
    end
    if (out_load) begin
      if (state_r == ST_EMIT2 || job_r.kind == JOB_SINGLE) begin
        out_x <= job_r.new_x;
        out_y <= job_r.new_y;
        out_pressure <= job_r.new_p;
        out_time <= job_r.new_t;
        out_last <= 1'b1;
      end else begin
        out_x <= (job_r.kind == JOB_SMOOTH) ? res_x_r : job_r.held_x;
        out_y <= (job_r.kind == JOB_SMOOTH) ? res_y_r : job_r.held_y;
        out_pressure <= job_r.held_p;
        out_time <= job_r.held_t;
        out_last <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/adaptive_stroke_smoother.sv
// Top level of the adaptive stroke smoother: configuration registers,
// front end, job queue and back end. Depends on asm_pkg and all rtl modules.
//
// The front end takes one point per cycle while the two-entry job queue has
// room; a stroke's first point is held and issues a job only if it ends the
// stroke. The back end is a sequencer that works on one job at a time: a
// smoothed point takes queue pop, six arithmetic steps through the multiply
// and compare path and output load; a passed point skips the arithmetic; a
// stroke's last point adds an output load unless it is the first. The output
// register lets the back end finish its next job while a result waits to be
// taken. Configuration writes take effect on the next smoothed point.
module adaptive_stroke_smoother import asm_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic [PRES_W-1:0]             in_pressure,
  input  logic [TIME_W-1:0]             in_time,
  input  logic                          in_stroke_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic [PRES_W-1:0]             out_pressure,
  output logic [TIME_W-1:0]             out_time,
  output logic                          out_last
);

  localparam int JOB_W = 6 * COORD_WIDTH + 131;

  cfg_t             cfg_r;
  logic [SF_W-1:0]  sf_wr;
  logic             job_push, job_full, job_valid, job_pop;
  logic [JOB_W-1:0] push_data, pop_data;

  assign sf_wr = (cfg_wdata[SF_W-1:0] > SF_ONE) ? SF_ONE : cfg_wdata[SF_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.smooth_factor <= SF_RESET;
      cfg_r.speed_limit <= SPEED_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SMOOTH_FACTOR: cfg_r.smooth_factor <= sf_wr;
        REG_SPEED_LIMIT:   cfg_r.speed_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  asm_front #(.CW(COORD_WIDTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_x         (in_x),
    .in_y         (in_y),
    .in_pressure  (in_pressure),
    .in_time      (in_time),
    .in_stroke_end(in_stroke_end),
    .job_push     (job_push),
    .job_data     (push_data),
    .job_full     (job_full)
  );

  asm_queue #(.DATA_W(JOB_W)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_data(push_data),
    .full     (job_full),
    .pop      (job_pop),
    .pop_valid(job_valid),
    .pop_data (pop_data)
  );

  asm_back #(.CW(COORD_WIDTH)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .job_valid   (job_valid),
    .job_data    (pop_data),
    .job_pop     (job_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_pressure(out_pressure),
    .out_time    (out_time),
    .out_last    (out_last)
  );

endmodule
